FILE: src/gig_pkg.sv
// shared constants and types for the gaussian integer gcd block
`timescale 1ns / 1ps
`default_nettype none
package gig_pkg;
  localparam int DataWidthDef = 31;
  localparam int RoundCapDef  = 128;
  localparam int RoundBits    = 8;
  localparam int AccWidth     = 64;

  // multiply-accumulate operations of the shared unit
  typedef enum logic [1:0] {
    MAC_LOAD = 2'd0,
    MAC_ADD  = 2'd1,
    MAC_SUB  = 2'd2
  } mac_op_t;

  // request to the shared multiply-accumulate unit
  typedef struct packed {
    logic    en;
    mac_op_t op;
  } mac_ctl_t;
endpackage
`default_nettype wire

FILE: src/gaussian_integer_gcd.sv
// top level: sequencer around one multiply-accumulate unit and one divider
//
// Computes a greatest common divisor of two Gaussian integers by Euclidean
// rounds: q = round(a*conj(b)/N(b)) per part (halves away from zero), then
// (a, b) <= (b, a - q*b) until N(b) is zero. The result is any associate.
// One item at a time: in_ready is high only while idle. Each round computes
// the norm, then two quotient passes (two products, then a 64-step bit-serial
// divide plus its start and finish) and the two remainder parts; at most 128
// rounds run per item, and the result then waits for out_ready.
`timescale 1ns / 1ps
`default_nettype none
module gaussian_integer_gcd
  import gig_pkg::*;
#(
  parameter int DATA_WIDTH = DataWidthDef
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [DATA_WIDTH-1:0] in_first_re,
  input  wire logic signed [DATA_WIDTH-1:0] in_first_im,
  input  wire logic signed [DATA_WIDTH-1:0] in_second_re,
  input  wire logic signed [DATA_WIDTH-1:0] in_second_im,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0]      out_gcd_re,
  output logic signed [DATA_WIDTH-1:0]      out_gcd_im
);
  // operands and quotient parts stay within DATA_WIDTH+2 bits
  localparam int OpW = DATA_WIDTH + 2;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_NB0  = 11'b00000000010,
    S_NB1  = 11'b00000000100,
    S_NCHK = 11'b00000001000,
    S_NUM  = 11'b00000010000,
    S_DIV  = 11'b00000100000,
    S_R0   = 11'b00001000000,
    S_R1   = 11'b00010000000,
    S_RSAV = 11'b00100000000,
    S_OUT  = 11'b01000000000,
    S_WAIT = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic signed [OpW-1:0] ar_r, ai_r, br_r, bi_r, qr_r, qi_r;
  logic signed [AccWidth-1:0] nb_r;
  logic [1:0] step_r, step_nxt;   // sub-step within a multi-cycle state
  logic part_r, part_nxt;         // 0: real part, 1: imaginary part
  logic [RoundBits-1:0] round_r, round_nxt;
  logic neg_r;
  logic signed [DATA_WIDTH-1:0] ore_r, oim_r;
  logic ovalid_r;

  mac_ctl_t mac_ctl;
  logic signed [OpW-1:0] mac_a, mac_b;
  logic signed [AccWidth-1:0] acc;
  logic div_start;
  logic div_done;
  logic [AccWidth-1:0] dnum, quo;
  logic signed [AccWidth-1:0] qsig;

  gig_mac #(.OpWidth(OpW)) u_mac (
    .clk(clk), .ctl(mac_ctl), .op_a(mac_a), .op_b(mac_b), .acc(acc)
  );

  gig_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(dnum), .den(nb_r),
    .done(div_done), .quo(quo)
  );

  // magnitude plus truncated half divisor feeds the divider
  always_comb begin
    if (acc < 0) dnum = AccWidth'(-acc) + AccWidth'(nb_r >>> 1);
    else         dnum = AccWidth'(acc) + AccWidth'(nb_r >>> 1);
    qsig = neg_r ? -$signed(quo) : $signed(quo);
  end

  // operand selection of the shared multiplier per state and sub-step
  always_comb begin
    mac_ctl = '{en: 1'b0, op: MAC_LOAD};
    mac_a   = br_r;
    mac_b   = br_r;
    case (state_r)
      S_NB0: begin
        mac_ctl = '{en: 1'b1, op: MAC_LOAD};
      end
      S_NB1: begin
        mac_ctl = '{en: 1'b1, op: MAC_ADD};
        mac_a = bi_r; mac_b = bi_r;
      end
      S_NUM: begin
        // re: ar*br + ai*bi, im: ai*br - ar*bi
        mac_ctl.en = 1'b1;
        if (step_r == 2'd0) begin
          mac_ctl.op = MAC_LOAD;
          mac_a = part_r ? ai_r : ar_r; mac_b = br_r;
        end else begin
          mac_ctl.op = part_r ? MAC_SUB : MAC_ADD;
          mac_a = part_r ? ar_r : ai_r; mac_b = bi_r;
        end
      end
      S_R0: begin
        // re: ar - qr*br + qi*bi, im: ai - qi*br - qr*bi
        mac_ctl.en = 1'b1;
        if (step_r == 2'd0) begin
          mac_ctl.op = MAC_LOAD;
          mac_a = part_r ? ai_r : ar_r; mac_b = OpW'(1);
        end else if (step_r == 2'd1) begin
          mac_ctl.op = MAC_SUB;
          mac_a = part_r ? qi_r : qr_r; mac_b = br_r;
        end else begin
          mac_ctl.op = part_r ? MAC_SUB : MAC_ADD;
          mac_a = part_r ? qr_r : qi_r; mac_b = bi_r;
        end
      end
      default: ;
    endcase
  end

  // round sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    part_nxt  = part_r;
    round_nxt = round_r;
    div_start = 1'b0;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_NB0;
      S_NB0:  state_nxt = S_NB1;
      S_NB1:  state_nxt = S_NCHK;
      S_NCHK: begin
        // the fresh norm is in the accumulator this cycle
        step_nxt = 2'd0;
        part_nxt = 1'b0;
        if (acc == 0 || round_r == RoundBits'(RoundCapDef)) state_nxt = S_OUT;
        else state_nxt = S_NUM;
      end
      S_NUM: begin
        if (step_r == 2'd0) step_nxt = 2'd1;
        else begin
          step_nxt = 2'd2;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (step_r == 2'd2) begin
          div_start = 1'b1;
          step_nxt = 2'd0;
        end else if (div_done) begin
          if (part_r) begin
            part_nxt = 1'b0;
            state_nxt = S_R0;
          end else begin
            part_nxt = 1'b1;
            state_nxt = S_NUM;
          end
        end
      end
      S_R0: begin
        if (step_r == 2'd2) begin
          step_nxt = 2'd0;
          state_nxt = S_R1;
        end else step_nxt = step_r + 2'd1;
      end
      S_R1:   state_nxt = S_RSAV;
      S_RSAV: begin
        if (part_r) begin
          part_nxt  = 1'b0;
          round_nxt = round_r + 1'b1;
          state_nxt = S_NB0;
        end else begin
          part_nxt  = 1'b1;
          state_nxt = S_R0;
        end
      end
      S_OUT:  state_nxt = S_WAIT;
      S_WAIT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= '0;
      part_r   <= 1'b0;
      round_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      part_r   <= part_nxt;
      round_r  <= (state_r == S_IDLE) ? '0 : round_nxt;
      if (state_r == S_OUT) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
    end
  end

  // datapath registers; the real part of the remainder waits in rr_r
  // until the imaginary part is done, then both operands shift over
  logic signed [OpW-1:0] rr_r;
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      ar_r <= OpW'(in_first_re);
      ai_r <= OpW'(in_first_im);
      br_r <= OpW'(in_second_re);
      bi_r <= OpW'(in_second_im);
    end
    if (state_r == S_NCHK) nb_r <= acc;
    if (state_r == S_DIV && step_r == 2'd2) neg_r <= acc[AccWidth-1];
    if (state_r == S_DIV && div_done) begin
      if (part_r) qi_r <= OpW'(qsig);
      else        qr_r <= OpW'(qsig);
    end
    if (state_r == S_RSAV) begin
      if (!part_r) rr_r <= OpW'(acc);
      else begin
        ar_r <= br_r;
        ai_r <= bi_r;
        br_r <= rr_r;
        bi_r <= OpW'(acc);
      end
    end
    if (state_r == S_OUT) begin
      ore_r <= DATA_WIDTH'(ar_r);
      oim_r <= DATA_WIDTH'(ai_r);
    end
  end

  // handshake outputs
  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = ovalid_r;
  assign out_gcd_re = ore_r;
  assign out_gcd_im = oim_r;

  // sequencer checks
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_gcd_re))
    else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("accepting while result pending");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> state_r == S_DIV)
    else $error("divider started outside divide state");
endmodule
`default_nettype wire

FILE: src/gig_mac.sv
// shared signed multiplier with combinational product and registered accumulator
`timescale 1ns / 1ps
`default_nettype none
module gig_mac
  import gig_pkg::*;
#(
  parameter int OpWidth = 33
) (
  input  wire logic                       clk,
  input  wire mac_ctl_t                   ctl,
  input  wire logic signed [OpWidth-1:0]  op_a,
  input  wire logic signed [OpWidth-1:0]  op_b,
  output logic signed [AccWidth-1:0]      acc
);
  logic signed [AccWidth-1:0] prod;
  logic signed [AccWidth-1:0] acc_r;
  logic signed [AccWidth-1:0] acc_nxt;

  // one product per cycle while ctl.en is set, folded into the accumulator
  always_comb begin
    prod = AccWidth'(op_a * op_b);
    case (ctl.op)
      MAC_LOAD: acc_nxt = prod;
      MAC_ADD:  acc_nxt = acc_r + prod;
      MAC_SUB:  acc_nxt = acc_r - prod;
      default:  acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en) acc_r <= acc_nxt;
  end

  assign acc = acc_r;
endmodule
`default_nettype wire

FILE: src/gig_div.sv
// restoring divider, one quotient bit per cycle, unsigned
`timescale 1ns / 1ps
`default_nettype none
module gig_div
  import gig_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [AccWidth-1:0] num,
  input  wire logic [AccWidth-1:0] den,
  output logic                     done,
  output logic [AccWidth-1:0]      quo
);
  localparam int CntBits = $clog2(AccWidth + 1);
  logic [AccWidth-1:0] q_r, q_nxt;
  logic [AccWidth:0]   rem_r, rem_nxt;
  logic [AccWidth-1:0] den_r;
  logic [CntBits-1:0]  cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [AccWidth:0]   trial;

  // shift one numerator bit in, subtract when it fits
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[AccWidth-1:0], q_r[AccWidth-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = CntBits'(AccWidth);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[AccWidth-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[AccWidth-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntBits'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule
`default_nettype wire
